FILE: rtl/rlbc_pkg.sv
`default_nettype none

package rlbc_pkg;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SET  = 2'd1;
  localparam logic [1:0] OP_GET  = 2'd2;

  localparam logic [7:0] CMD_POWER  = 8'h01;
  localparam logic [7:0] CMD_COLOUR = 8'h02;
  localparam logic [7:0] CMD_LEVELS = 8'h03;
  localparam logic [7:0] CMD_BLINK  = 8'h04;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ERROR   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [7:0] NUM_COLOURS = 8'h08;
  localparam int unsigned TickMs = 10;

  // Scale factors for the blink compares, which avoid any division at run time.
  localparam logic [27:0] ON_SCALE  = 28'(255 * TickMs);
  localparam logic [27:0] ON_OFFSET = 28'(255 * (TickMs / 2));
  localparam logic [19:0] LIM_SCALE = 20'(TickMs);
  localparam logic [19:0] LIM_BIAS  = 20'(TickMs - 1);

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] cmd;
    logic [7:0] arg0;
    logic [7:0] arg1;
    logic [7:0] arg2;
    logic [1:0] arg_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] reply_length;
    logic [7:0] reply0;
    logic [7:0] reply1;
    logic [7:0] reply2;
    logic [7:0] red_drive;
    logic [7:0] green_drive;
    logic [7:0] blue_drive;
  } out_item_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } in_stage_t;

  typedef struct packed {
    logic      advance;
    out_item_t result;
  } res_stage_t;

  function automatic logic [23:0] colour_rgb(input logic [2:0] idx);
    logic [23:0] rgb;
    unique case (idx)
      3'd0: rgb = 24'h000000;
      3'd1: rgb = 24'hFF0000;
      3'd2: rgb = 24'hFFFF00;
      3'd3: rgb = 24'h00FF00;
      3'd4: rgb = 24'h00FFFF;
      3'd5: rgb = 24'h0000FF;
      3'd6: rgb = 24'hFF00FF;
      3'd7: rgb = 24'hFFFFFF;
      default: rgb = 24'h000000;
    endcase
    return rgb;
  endfunction

  function automatic logic [7:0] drive_level(input logic cathode, input logic shown,
                                             input logic [7:0] level);
    logic [7:0] drv;
    if (cathode) begin
      drv = shown ? level : 8'h00;
    end else begin
      drv = shown ? ~level : 8'hFF;
    end
    return drv;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/rlbc_in_if.sv
`default_nettype none

interface rlbc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] cmd;
  logic [7:0] arg0;
  logic [7:0] arg1;
  logic [7:0] arg2;
  logic [1:0] arg_count;

  modport source(output valid, op, cmd, arg0, arg1, arg2, arg_count, input ready);
  modport sink(input valid, op, cmd, arg0, arg1, arg2, arg_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/rlbc_out_if.sv
`default_nettype none

interface rlbc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [1:0] reply_length;
  logic [7:0] reply0;
  logic [7:0] reply1;
  logic [7:0] reply2;
  logic [7:0] red_drive;
  logic [7:0] green_drive;
  logic [7:0] blue_drive;

  modport source(output valid, status, reply_length, reply0, reply1, reply2,
                 red_drive, green_drive, blue_drive, input ready);
  modport sink(input valid, status, reply_length, reply0, reply1, reply2,
               red_drive, green_drive, blue_drive, output ready);
endinterface

`default_nettype wire

FILE: rtl/rlbc_in_reg.sv
`default_nettype none

module rlbc_in_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  rlbc_in_if.sink                in_i,
  input  wire logic              advance_i,
  output rlbc_pkg::in_stage_t    stage_o
);

  logic               valid_q;
  logic               valid_d;
  rlbc_pkg::in_item_t item_q;
  logic               ready;

  assign ready = !valid_q || advance_i;
  assign in_i.ready = ready;

  always_comb begin
    valid_d = valid_q;
    if (ready) begin
      valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && in_i.valid) begin
      item_q <= '{op: in_i.op, cmd: in_i.cmd, arg0: in_i.arg0, arg1: in_i.arg1,
                  arg2: in_i.arg2, arg_count: in_i.arg_count};
    end
  end

  assign stage_o = '{valid: valid_q, item: item_q};

endmodule

`default_nettype wire

FILE: rtl/rlbc_engine.sv
`default_nettype none

module rlbc_engine (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_data_i,
  input  rlbc_pkg::in_stage_t    stage_i,
  input  wire logic              can_take_i,
  output rlbc_pkg::res_stage_t   res_o
);

  logic        cathode_q;
  logic        power_q, power_d;
  logic [7:0]  red_q, red_d;
  logic [7:0]  green_q, green_d;
  logic [7:0]  blue_q, blue_d;
  logic [15:0] period_q, period_d;
  logic [7:0]  duty_q, duty_d;
  logic [23:0] product_q, product_d;
  logic [15:0] tick_q, tick_d;
  logic        phase_q, phase_d;
  logic        shown_q, shown_d;

  logic                advance;
  rlbc_pkg::in_item_t  it;
  rlbc_pkg::out_item_t res;
  logic                on_window;
  logic [15:0]         tick_next;
  logic                wrap;
  logic [2:0]          match_idx;
  logic [23:0]         colour;

  assign it = stage_i.item;
  assign advance = stage_i.valid && can_take_i;

  // The LED is lit while 255*TickMs*t + 255*(TickMs/2) <= period*duty.
  assign on_window = ({12'b0, tick_q} * rlbc_pkg::ON_SCALE + rlbc_pkg::ON_OFFSET)
                     <= {4'b0, product_q};
  assign tick_next = tick_q + 16'd1;
  assign wrap = ({4'b0, tick_next} * rlbc_pkg::LIM_SCALE + rlbc_pkg::LIM_BIAS)
                >= {4'b0, period_q};
  assign colour = rlbc_pkg::colour_rgb(it.arg0[2:0]);

  always_comb begin
    match_idx = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if ({red_q, green_q, blue_q} == rlbc_pkg::colour_rgb(3'(k))) begin
        match_idx = 3'(k);
      end
    end
  end

  always_comb begin
    power_d   = power_q;
    red_d     = red_q;
    green_d   = green_q;
    blue_d    = blue_q;
    period_d  = period_q;
    duty_d    = duty_q;
    product_d = product_q;
    tick_d    = tick_q;
    phase_d   = phase_q;
    shown_d   = shown_q;
    res       = '0;
    res.status = rlbc_pkg::ST_OK;

    unique case (it.op)
      rlbc_pkg::OP_TICK: begin
        if (power_q) begin
          if (on_window && !phase_q) begin
            phase_d = 1'b1;
            shown_d = 1'b1;
          end else if (!on_window && phase_q) begin
            phase_d = 1'b0;
            shown_d = 1'b0;
          end
          tick_d = wrap ? 16'd0 : tick_next;
        end
      end
      rlbc_pkg::OP_SET: begin
        unique case (it.cmd)
          rlbc_pkg::CMD_POWER: begin
            if (it.arg_count != 2'd1) begin
              res.status = rlbc_pkg::ST_INVALID;
            end else begin
              power_d = |it.arg0;
            end
          end
          rlbc_pkg::CMD_COLOUR: begin
            if (it.arg_count != 2'd1) begin
              res.status = rlbc_pkg::ST_INVALID;
            end else if (it.arg0 >= rlbc_pkg::NUM_COLOURS) begin
              res.status = rlbc_pkg::ST_ERROR;
            end else begin
              red_d   = colour[23:16];
              green_d = colour[15:8];
              blue_d  = colour[7:0];
            end
          end
          rlbc_pkg::CMD_LEVELS: begin
            if (it.arg_count != 2'd3) begin
              res.status = rlbc_pkg::ST_INVALID;
            end else begin
              red_d   = it.arg0;
              green_d = it.arg1;
              blue_d  = it.arg2;
            end
          end
          rlbc_pkg::CMD_BLINK: begin
            if (it.arg_count != 2'd3) begin
              res.status = rlbc_pkg::ST_INVALID;
            end else begin
              period_d  = {it.arg0, it.arg1};
              duty_d    = it.arg2;
              product_d = {it.arg0, it.arg1} * {16'b0, it.arg2};
            end
          end
          default: res.status = rlbc_pkg::ST_INVALID;
        endcase
        if (res.status == rlbc_pkg::ST_OK) begin
          shown_d = power_d;
        end
      end
      rlbc_pkg::OP_GET: begin
        unique case (it.cmd)
          rlbc_pkg::CMD_POWER: begin
            res.reply_length = 2'd1;
            res.reply0       = {7'b0, power_q};
          end
          rlbc_pkg::CMD_COLOUR: begin
            res.reply_length = 2'd1;
            res.reply0       = {5'b0, match_idx};
          end
          rlbc_pkg::CMD_LEVELS: begin
            res.reply_length = 2'd3;
            res.reply0       = red_q;
            res.reply1       = green_q;
            res.reply2       = blue_q;
          end
          rlbc_pkg::CMD_BLINK: begin
            res.reply_length = 2'd3;
            res.reply0       = period_q[7:0];
            res.reply1       = period_q[15:8];
            res.reply2       = duty_q;
          end
          default: res.status = rlbc_pkg::ST_INVALID;
        endcase
      end
      default: res.status = rlbc_pkg::ST_INVALID;
    endcase

    res.red_drive   = rlbc_pkg::drive_level(cathode_q, shown_d, red_d);
    res.green_drive = rlbc_pkg::drive_level(cathode_q, shown_d, green_d);
    res.blue_drive  = rlbc_pkg::drive_level(cathode_q, shown_d, blue_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cathode_q <= 1'b1;
    end else if (cfg_we_i) begin
      cathode_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q   <= 1'b0;
      red_q     <= '0;
      green_q   <= '0;
      blue_q    <= '0;
      period_q  <= '0;
      duty_q    <= '0;
      product_q <= '0;
      tick_q    <= '0;
      phase_q   <= 1'b0;
      shown_q   <= 1'b0;
    end else if (advance) begin
      power_q   <= power_d;
      red_q     <= red_d;
      green_q   <= green_d;
      blue_q    <= blue_d;
      period_q  <= period_d;
      duty_q    <= duty_d;
      product_q <= product_d;
      tick_q    <= tick_d;
      phase_q   <= phase_d;
      shown_q   <= shown_d;
    end
  end

  assign res_o = '{advance: advance, result: res};

endmodule

`default_nettype wire

FILE: rtl/rlbc_out_reg.sv
`default_nettype none

module rlbc_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  rlbc_pkg::res_stage_t   res_i,
  output logic                   can_take_o,
  rlbc_out_if.source             out_o
);

  logic                valid_q;
  logic                valid_d;
  rlbc_pkg::out_item_t item_q;

  assign can_take_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (can_take_o) begin
      valid_d = res_i.advance;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.advance) begin
      item_q <= res_i.result;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.status       = item_q.status;
  assign out_o.reply_length = item_q.reply_length;
  assign out_o.reply0       = item_q.reply0;
  assign out_o.reply1       = item_q.reply1;
  assign out_o.reply2       = item_q.reply2;
  assign out_o.red_drive    = item_q.red_drive;
  assign out_o.green_drive  = item_q.green_drive;
  assign out_o.blue_drive   = item_q.blue_drive;

endmodule

`default_nettype wire

FILE: rtl/rgb_led_blink_controller_core.sv
// RGB LED controller with blinking: takes one tick, set or get item per clock and returns
// one result per item, passed through an input register and then the result register. The
// rate of one item per cycle is held as long as results are taken; in_i.ready follows
// out_o.ready combinationally through the single engine stage, so a stalled result holds
// the input register and the item behind it. Each result carries the status, the reply
// bytes of a get, and the drive levels after the item, inverted when common_cathode is
// written 0. Write the common_cathode register only while no transfer is in flight.

`default_nettype none

module rgb_led_blink_controller_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic  cfg_data_i,
  rlbc_in_if.sink    in_i,
  rlbc_out_if.source out_o
);

  rlbc_pkg::in_stage_t  in_stage;
  rlbc_pkg::res_stage_t res_stage;
  logic                 can_take;

  rlbc_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (res_stage.advance),
    .stage_o   (in_stage)
  );

  rlbc_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .stage_i    (in_stage),
    .can_take_i (can_take),
    .res_o      (res_stage)
  );

  rlbc_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_i      (res_stage),
    .can_take_o (can_take),
    .out_o      (out_o)
  );

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stage.valid |-> in_i.ready)
    else $error("Input side not ready while its register is empty.");

  a_no_advance_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !res_stage.advance)
    else $error("Engine advanced while the result register was stalled.");

  a_transfer_reaches_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_stage.advance |=> out_o.valid)
    else $error("Processed item did not reach the result register.");

  a_reply_only_when_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.reply_length == 2'd0 || out_o.status == rlbc_pkg::ST_OK))
    else $error("Reply bytes reported with a failing status.");

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // Palette entries, index 0 in the low bits.
  localparam logic [7:0][23:0] PALETTE = {
    24'hFFFFFF, 24'hFF00FF, 24'h0000FF, 24'h00FFFF,
    24'h00FF00, 24'hFFFF00, 24'hFF0000, 24'h000000
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_data;

  rlbc_in_if  in_bus();
  rlbc_out_if out_bus();

  rgb_led_blink_controller_core dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_data_i(cfg_data),
    .in_i      (in_bus),
    .out_o     (out_bus)
  );

  logic        cathode_mode = 1'b1;
  logic        led_power = 1'b0;
  logic [7:0]  led_red = '0;
  logic [7:0]  led_green = '0;
  logic [7:0]  led_blue = '0;
  logic [15:0] blink_period = '0;
  logic [7:0]  blink_duty = '0;
  logic [15:0] tick_pos = '0;
  logic        blink_phase = 1'b0;
  logic        shown = 1'b0;

  rlbc_pkg::out_item_t expected_results[$];
  rlbc_pkg::out_item_t oldest_result;
  int unsigned         mismatches = 0;
  int unsigned         cycle_count = 0;
  int unsigned         result_hold_cycles = 0;
  bit                  feed_steady = 1'b0;
  bit                  drain_steady = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [7:0] led_drive(logic [7:0] lvl);
    if (cathode_mode) begin
      return shown ? lvl : 8'h00;
    end
    return shown ? 8'(8'd255 - lvl) : 8'hFF;
  endfunction

  function automatic rlbc_pkg::out_item_t predict_led_item(rlbc_pkg::in_item_t it);
    rlbc_pkg::out_item_t r;
    logic [31:0]         on_ms;
    logic [31:0]         on_ticks;
    logic [31:0]         wrap_at;
    logic [23:0]         rgb;
    logic                applied;
    r = '0;
    r.status = rlbc_pkg::ST_OK;
    applied = 1'b0;
    case (it.op)
      rlbc_pkg::OP_TICK: begin
        if (led_power) begin
          on_ms = (32'(blink_period) * 32'(blink_duty)) / 32'd255;
          on_ticks = (on_ms + 32'(rlbc_pkg::TickMs / 2)) / 32'(rlbc_pkg::TickMs);
          if (32'(tick_pos) < on_ticks) begin
            if (!blink_phase) begin
              shown = 1'b1;
              blink_phase = 1'b1;
            end
          end else if (blink_phase) begin
            shown = 1'b0;
            blink_phase = 1'b0;
          end
          tick_pos = tick_pos + 16'd1;
          wrap_at = 32'(blink_period) / 32'(rlbc_pkg::TickMs);
          if (32'(tick_pos) >= wrap_at) begin
            tick_pos = '0;
          end
        end
      end
      rlbc_pkg::OP_SET: begin
        case (it.cmd)
          rlbc_pkg::CMD_POWER: begin
            if (it.arg_count != 2'd1) begin
              r.status = rlbc_pkg::ST_INVALID;
            end else begin
              led_power = (it.arg0 != 8'h00);
              applied = 1'b1;
            end
          end
          rlbc_pkg::CMD_COLOUR: begin
            if (it.arg_count != 2'd1) begin
              r.status = rlbc_pkg::ST_INVALID;
            end else if (it.arg0 >= rlbc_pkg::NUM_COLOURS) begin
              r.status = rlbc_pkg::ST_ERROR;
            end else begin
              rgb = PALETTE[it.arg0[2:0]];
              {led_red, led_green, led_blue} = rgb;
              applied = 1'b1;
            end
          end
          rlbc_pkg::CMD_LEVELS: begin
            if (it.arg_count != 2'd3) begin
              r.status = rlbc_pkg::ST_INVALID;
            end else begin
              {led_red, led_green, led_blue} = {it.arg0, it.arg1, it.arg2};
              applied = 1'b1;
            end
          end
          rlbc_pkg::CMD_BLINK: begin
            if (it.arg_count != 2'd3) begin
              r.status = rlbc_pkg::ST_INVALID;
            end else begin
              blink_period = {it.arg0, it.arg1};
              blink_duty = it.arg2;
              applied = 1'b1;
            end
          end
          default: r.status = rlbc_pkg::ST_INVALID;
        endcase
        if (applied) begin
          shown = led_power;
        end
      end
      rlbc_pkg::OP_GET: begin
        case (it.cmd)
          rlbc_pkg::CMD_POWER: begin
            r.reply_length = 2'd1;
            r.reply0 = {7'd0, led_power};
          end
          rlbc_pkg::CMD_COLOUR: begin
            r.reply_length = 2'd1;
            for (int k = 7; k >= 0; k--) begin
              if ({led_red, led_green, led_blue} == PALETTE[k]) begin
                r.reply0 = 8'(k);
              end
            end
          end
          rlbc_pkg::CMD_LEVELS: begin
            r.reply_length = 2'd3;
            {r.reply0, r.reply1, r.reply2} = {led_red, led_green, led_blue};
          end
          rlbc_pkg::CMD_BLINK: begin
            r.reply_length = 2'd3;
            {r.reply0, r.reply1, r.reply2} = {blink_period[7:0], blink_period[15:8], blink_duty};
          end
          default: r.status = rlbc_pkg::ST_INVALID;
        endcase
      end
      default: r.status = rlbc_pkg::ST_INVALID;
    endcase
    r.red_drive = led_drive(led_red);
    r.green_drive = led_drive(led_green);
    r.blue_drive = led_drive(led_blue);
    return r;
  endfunction

  function automatic rlbc_pkg::in_item_t make_item(logic [1:0] op, logic [7:0] cmd,
                                                   logic [7:0] a0, logic [7:0] a1,
                                                   logic [7:0] a2, logic [1:0] cnt);
    rlbc_pkg::in_item_t it;
    it.op = op;
    it.cmd = cmd;
    it.arg0 = a0;
    it.arg1 = a1;
    it.arg2 = a2;
    it.arg_count = cnt;
    return it;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic rlbc_pkg::in_item_t random_item();
    logic [7:0] cmd;
    cmd = $urandom_range(0, 1) ? 8'($urandom_range(0, 5)) : rand_byte();
    return make_item(2'($urandom_range(0, 3)), cmd, rand_byte(), rand_byte(), rand_byte(),
                     2'($urandom_range(0, 3)));
  endfunction

  task automatic send_item(rlbc_pkg::in_item_t it);
    @(negedge clk);
    while (!feed_steady && $urandom_range(0, 99) < 23) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.op = it.op;
    in_bus.cmd = it.cmd;
    in_bus.arg0 = it.arg0;
    in_bus.arg1 = it.arg1;
    in_bus.arg2 = it.arg2;
    in_bus.arg_count = it.arg_count;
    @(posedge clk);
    while (!in_bus.ready) begin
      @(posedge clk);
    end
    expected_results.push_back(predict_led_item(it));
  endtask

  task automatic settle_block();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cathode(logic value);
    settle_block();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    cathode_mode = value;
  endtask

  task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // One colour or level setting, a blink setting, power on, then mostly ticks; sometimes power off and further ticks.
  task automatic run_blink_sequence();
    logic [15:0] period;
    logic [7:0]  duty;
    int unsigned steps;
    if ($urandom_range(0, 1)) begin
      send_item(make_item(rlbc_pkg::OP_SET, rlbc_pkg::CMD_COLOUR, 8'($urandom_range(0, 7)),
                          rand_byte(), rand_byte(), 2'd1));
    end else begin
      send_item(make_item(rlbc_pkg::OP_SET, rlbc_pkg::CMD_LEVELS, rand_byte(), rand_byte(),
                          rand_byte(), 2'd3));
    end
    case ($urandom_range(0, 9))
      0: period = 16'($urandom_range(0, 65535));
      1: period = 16'($urandom_range(0, 9));
      default: period = 16'($urandom_range(10, 250));
    endcase
    case ($urandom_range(0, 5))
      0: duty = 8'h00;
      1: duty = 8'hFF;
      default: duty = rand_byte();
    endcase
    send_item(make_item(rlbc_pkg::OP_SET, rlbc_pkg::CMD_BLINK, period[15:8], period[7:0],
                        duty, 2'd3));
    send_item(make_item(rlbc_pkg::OP_SET, rlbc_pkg::CMD_POWER, 8'($urandom_range(1, 255)),
                        rand_byte(), rand_byte(), 2'd1));
    steps = $urandom_range(4, 30);
    repeat (steps) begin
      case ($urandom_range(0, 15))
        0, 1: send_item(make_item(rlbc_pkg::OP_GET, 8'($urandom_range(1, 4)), rand_byte(),
                                  rand_byte(), rand_byte(), 2'($urandom_range(0, 3))));
        2: send_item(make_item(rlbc_pkg::OP_SET, rlbc_pkg::CMD_LEVELS, rand_byte(),
                               rand_byte(), rand_byte(), 2'd3));
        3: send_item(make_item(rlbc_pkg::OP_SET, rlbc_pkg::CMD_BLINK, 8'h00,
                               8'($urandom_range(0, 200)), rand_byte(), 2'd3));
        default: send_item(make_item(rlbc_pkg::OP_TICK, rand_byte(), rand_byte(),
                                     rand_byte(), rand_byte(), 2'($urandom_range(0, 3))));
      endcase
    end
    if ($urandom_range(0, 3) == 0) begin
      send_item(make_item(rlbc_pkg::OP_SET, rlbc_pkg::CMD_POWER, 8'h00, rand_byte(),
                          rand_byte(), 2'd1));
      repeat (3) send_item(make_item(rlbc_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0));
    end
  endtask

  task automatic test_directed();
    write_cathode(1'b1);
    send_item(make_item(rlbc_pkg::OP_GET, rlbc_pkg::CMD_POWER, 8'h00, 8'h00, 8'h00, 2'd0));
    send_item(make_item(rlbc_pkg::OP_GET, rlbc_pkg::CMD_COLOUR, 8'h00, 8'h00, 8'h00, 2'd3));
    send_item(make_item(rlbc_pkg::OP_GET, rlbc_pkg::CMD_LEVELS, 8'hFF, 8'hFF, 8'hFF, 2'd1));
    send_item(make_item(rlbc_pkg::OP_GET, rlbc_pkg::CMD_BLINK, 8'h00, 8'h00, 8'h00, 2'd0));
    send_item(make_item(rlbc_pkg::OP_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd3));
    send_item(make_item(rlbc_pkg::OP_SET, rlbc_pkg::CMD_POWER, 8'h01, 8'h00, 8'h00, 2'd0));
    send_item(make_item(rlbc_pkg::OP_SET, rlbc_pkg::CMD_POWER, 8'h01, 8'h00, 8'h00, 2'd2));
    send_item(make_item(rlbc_pkg::OP_SET, rlbc_pkg::CMD_POWER, 8'h80, 8'h00, 8'h00, 2'd1));
    send_item(make_item(rlbc_pkg::OP_SET, rlbc_pkg::CMD_COLOUR, 8'h07, 8'h00, 8'h00, 2'd1));
    send_item(make_item(rlbc_pkg::OP_GET, rlbc_pkg::CMD_COLOUR, 8'h00, 8'h00, 8'h00, 2'd0));
    send_item(make_item(rlbc_pkg::OP_SET, rlbc_pkg::CMD_COLOUR, rlbc_pkg::NUM_COLOURS,
                        8'h00, 8'h00, 2'd1));
    send_item(make_item(rlbc_pkg::OP_SET, rlbc_pkg::CMD_COLOUR, 8'hFF, 8'h00, 8'h00, 2'd1));
    send_item(make_item(rlbc_pkg::OP_SET, rlbc_pkg::CMD_LEVELS, 8'hFF, 8'h00, 8'hA5, 2'd3));
    send_item(make_item(rlbc_pkg::OP_GET, rlbc_pkg::CMD_COLOUR, 8'h00, 8'h00, 8'h00, 2'd0));
    send_item(make_item(rlbc_pkg::OP_SET, rlbc_pkg::CMD_LEVELS, 8'h11, 8'h22, 8'h33, 2'd2));
    send_item(make_item(rlbc_pkg::OP_SET, rlbc_pkg::CMD_BLINK, 8'hFF, 8'hFF, 8'hFF, 2'd3));
    send_item(make_item(rlbc_pkg::OP_GET, rlbc_pkg::CMD_BLINK, 8'h00, 8'h00, 8'h00, 2'd0));
    send_item(make_item(rlbc_pkg::OP_SET, rlbc_pkg::CMD_BLINK, 8'h00, 8'd30, 8'd128, 2'd3));
    repeat (4) send_item(make_item(rlbc_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0));
    send_item(make_item(rlbc_pkg::OP_SET, 8'h00, 8'h01, 8'h02, 8'h03, 2'd3));
    send_item(make_item(rlbc_pkg::OP_SET, 8'hFF, 8'h01, 8'h02, 8'h03, 2'd1));
    send_item(make_item(rlbc_pkg::OP_GET, 8'hFF, 8'h00, 8'h00, 8'h00, 2'd0));
    send_item(make_item(OP_UNUSED, rlbc_pkg::CMD_POWER, 8'h01, 8'h00, 8'h00, 2'd1));
    send_item(make_item(rlbc_pkg::OP_SET, rlbc_pkg::CMD_POWER, 8'h00, 8'h00, 8'h00, 2'd1));
    send_item(make_item(rlbc_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0));
    settle_block();
  endtask

  task automatic test_blink_sequences();
    repeat (20) run_blink_sequence();
    settle_block();
  endtask

  task automatic test_common_anode();
    write_cathode(1'b0);
    repeat (4) run_blink_sequence();
    repeat (60) send_item(random_item());
    settle_block();
  endtask

  task automatic test_full_random();
    write_cathode(1'b1);
    repeat (125) send_item(random_item());
    write_cathode(1'b0);
    repeat (125) send_item(random_item());
    settle_block();
    write_cathode(1'b1);
  endtask

  // The result side holds off while items keep coming, so the input must stall.
  task automatic test_backpressure();
    feed_steady = 1'b1;
    result_hold_cycles = 300;
    repeat (4) run_blink_sequence();
    feed_steady = 1'b0;
    settle_block();
  endtask

  task automatic test_no_idle_stretch();
    feed_steady = 1'b1;
    drain_steady = 1'b1;
    repeat (6) run_blink_sequence();
    feed_steady = 1'b0;
    drain_steady = 1'b0;
    settle_block();
  endtask

  always @(negedge clk) begin
    if (result_hold_cycles > 0) begin
      out_bus.ready = 1'b0;
      result_hold_cycles--;
    end else begin
      out_bus.ready = drain_steady || ($urandom_range(0, 99) >= 23);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: transfer expected none, got status %0d", $time, out_bus.status);
      end else begin
        oldest_result = expected_results.pop_front();
        compare_field("status", 8'(oldest_result.status), 8'(out_bus.status));
        compare_field("reply_length", 8'(oldest_result.reply_length),
                      8'(out_bus.reply_length));
        compare_field("reply0", oldest_result.reply0, out_bus.reply0);
        compare_field("reply1", oldest_result.reply1, out_bus.reply1);
        compare_field("reply2", oldest_result.reply2, out_bus.reply2);
        compare_field("red_drive", oldest_result.red_drive, out_bus.red_drive);
        compare_field("green_drive", oldest_result.green_drive, out_bus.green_drive);
        compare_field("blue_drive", oldest_result.blue_drive, out_bus.blue_drive);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.op = rlbc_pkg::OP_TICK;
    in_bus.cmd = '0;
    in_bus.arg0 = '0;
    in_bus.arg1 = '0;
    in_bus.arg2 = '0;
    in_bus.arg_count = '0;
    out_bus.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_blink_sequences();
    test_common_anode();
    test_full_random();
    test_backpressure();
    test_no_idle_stretch();
    settle_block();

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
